// ----- design/mm3_pkg.sv -----
// Package for the MurmurHash3 (x86_32) string hash block.
// Holds the mixing constants, the controller-to-datapath command and status
// types, and the rotate helper. Depends on nothing.
`default_nettype none

package mm3_pkg;

	// Scramble and mixing constants of MurmurHash3 x86_32.
	localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
	localparam logic [31:0] MIX_C2  = 32'h1b873593;
	localparam logic [31:0] MIX_ADD = 32'he6546b64;
	localparam logic [31:0] FIN_M1  = 32'h85ebca6b;
	localparam logic [31:0] FIN_M2  = 32'hc2b2ae35;

	// Rotate amounts used by the scramble and the hash mix.
	localparam logic [4:0] ROT_K = 5'd15;
	localparam logic [4:0] ROT_H = 5'd13;

	// Commands issued by the controller to the datapath, one per cycle.
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_ACCEPT,
		CMD_TAIL_K1,
		CMD_K2,
		CMD_MIX,
		CMD_TAIL_X,
		CMD_FIN0,
		CMD_FIN1,
		CMD_FIN2
	} mm3_cmd_t;

	// Status returned by the datapath to the controller.
	typedef struct packed {
		logic word_full;  // three bytes held: the next byte completes a word
		logic phase_nz;   // leftover tail bytes are held
		logic out_free;   // output register can take a new result
	} mm3_status_t;

	// Left rotate of a 32-bit word.
	function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] r);
		logic [5:0] rr;
		rr = 6'd32 - {1'b0, r};
		return (v << r) | (v >> rr);
	endfunction

endpackage

`default_nettype wire

// ----- design/mm3_datapath.sv -----
// Datapath of the MurmurHash3 block: word assembly, scramble, hash mix,
// finalisation and the output register. Driven by commands from mm3_ctrl.
// Depends on mm3_pkg.
`default_nettype none

module mm3_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mm3_pkg::mm3_cmd_t  cmd,
	input  wire logic [7:0]         key_byte,
	input  wire logic               has_byte,
	output mm3_pkg::mm3_status_t    status,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [31:0]             hash_value
);
	import mm3_pkg::*;

	logic [23:0] partial_q;
	logic [1:0]  phase_q;
	logic [31:0] hash_q;
	logic [31:0] count_q;
	logic [31:0] work_q;
	logic [31:0] out_data_q;
	logic        out_valid_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] mul_p;
	logic [31:0] mix_rot;
	logic [31:0] mix_sum;
	logic [31:0] fin_x;
	logic [23:0] byte_ins;

	// The single shared multiplier: operand selection by command.
	always_comb begin
		fin_x = hash_q ^ count_q;
		unique case (cmd)
			CMD_ACCEPT: begin
				mul_a = {key_byte, partial_q};
				mul_b = MIX_C1;
			end
			CMD_TAIL_K1: begin
				mul_a = {8'h00, partial_q};
				mul_b = MIX_C1;
			end
			CMD_K2: begin
				mul_a = rotl32(work_q, ROT_K);
				mul_b = MIX_C2;
			end
			CMD_FIN0: begin
				mul_a = fin_x ^ (fin_x >> 16);
				mul_b = FIN_M1;
			end
			CMD_FIN1: begin
				mul_a = work_q ^ (work_q >> 13);
				mul_b = FIN_M2;
			end
			default: begin
				mul_a = work_q;
				mul_b = 32'd1;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// Hash mix: rotate, times five by shift and add, plus the constant.
	always_comb begin
		mix_rot  = rotl32(hash_q ^ work_q, ROT_H);
		mix_sum  = (mix_rot << 2) + mix_rot + MIX_ADD;
		byte_ins = 24'(key_byte) << {phase_q, 3'b000};
	end

	// Key state and work register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			phase_q   <= '0;
			hash_q    <= '0;
			count_q   <= '0;
			work_q    <= '0;
		end else begin
			unique case (cmd)
				CMD_ACCEPT: begin
					if (has_byte) begin
						if (phase_q == 2'd3) begin
							work_q    <= mul_p;
							partial_q <= '0;
							phase_q   <= '0;
						end else begin
							partial_q <= partial_q | byte_ins;
							phase_q   <= phase_q + 2'd1;
						end
						count_q <= count_q + 32'd1;
					end
				end
				CMD_TAIL_K1, CMD_K2, CMD_FIN0, CMD_FIN1: begin
					work_q <= mul_p;
				end
				CMD_MIX: begin
					hash_q <= mix_sum;
				end
				CMD_TAIL_X: begin
					hash_q <= hash_q ^ work_q;
				end
				CMD_FIN2: begin
					partial_q <= '0;
					phase_q   <= '0;
					hash_q    <= '0;
					count_q   <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Output register: holds a result until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd == CMD_FIN2) begin
				out_valid_q <= 1'b1;
				out_data_q  <= work_q ^ (work_q >> 16);
			end
		end
	end

	assign status.word_full = (phase_q == 2'd3);
	assign status.phase_nz  = (phase_q != 2'd0);
	assign status.out_free  = !out_valid_q || out_ready;
	assign out_valid  = out_valid_q;
	assign hash_value = out_data_q;

	// With phase zero, the partial word holds no bytes.
	a_partial_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == 2'd0) |-> (partial_q == 24'd0))
		else $error("partial word holds bytes with phase zero");

	// A new result is never written over one still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_data_q)))
		else $error("waiting result lost or changed");

	// Finalising clears the key length.
	a_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_FIN2) |=> (count_q == 32'd0 && phase_q == 2'd0))
		else $error("key state not cleared after finalisation");

endmodule

`default_nettype wire

// ----- design/mm3_ctrl.sv -----
// Controller of the MurmurHash3 block: sequences acceptance, word mixing,
// tail handling and finalisation as commands to mm3_datapath.
// Depends on mm3_pkg.
`default_nettype none

module mm3_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 has_byte,
	input  wire logic                 last,
	input  wire mm3_pkg::mm3_status_t status,
	output mm3_pkg::mm3_cmd_t         cmd
);
	import mm3_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_K2,
		ST_MIX,
		ST_TK1,
		ST_TK2,
		ST_TX,
		ST_F0,
		ST_F1,
		ST_F2
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   last_q;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Next state and the command for this cycle.
	always_comb begin
		state_d = state_q;
		cmd     = CMD_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd = CMD_ACCEPT;
					if (has_byte && status.word_full) begin
						state_d = ST_K2;
					end else if (last) begin
						state_d = ST_TK1;
					end
				end
			end
			ST_K2: begin
				cmd     = CMD_K2;
				state_d = ST_MIX;
			end
			ST_MIX: begin
				cmd     = CMD_MIX;
				state_d = last_q ? ST_TK1 : ST_IDLE;
			end
			ST_TK1: begin
				if (status.phase_nz) begin
					cmd     = CMD_TAIL_K1;
					state_d = ST_TK2;
				end else begin
					cmd     = CMD_FIN0;
					state_d = ST_F1;
				end
			end
			ST_TK2: begin
				cmd     = CMD_K2;
				state_d = ST_TX;
			end
			ST_TX: begin
				cmd     = CMD_TAIL_X;
				state_d = ST_F0;
			end
			ST_F0: begin
				cmd     = CMD_FIN0;
				state_d = ST_F1;
			end
			ST_F1: begin
				cmd     = CMD_FIN1;
				state_d = ST_F2;
			end
			ST_F2: begin
				if (status.out_free) begin
					cmd     = CMD_FIN2;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and the latched end-of-key flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				last_q <= last;
			end
		end
	end

	// A result is only produced when the output register is free.
	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_FIN2) |-> status.out_free)
		else $error("finalisation issued while output full");

	// A completed word is scrambled in the following cycle.
	a_word_mix: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && has_byte && status.word_full) |=> (cmd == CMD_K2))
		else $error("completed word not scrambled");

	// An item that neither completes a word nor ends the key leaves the input ready again in the next cycle.
	a_short_item: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !(has_byte && status.word_full) && !last) |=> in_ready)
		else $error("simple item did not return to idle");

endmodule

`default_nettype wire

// ----- design/murmur3_string_hash.sv -----
// MurmurHash3 x86_32 (seed 0) over a key streamed one byte per request.
//
// Input channel s_*: each request carries one key byte in s_tdata, a
// byte-present flag in s_tuser and the end of the key in s_tlast. A request
// with s_tuser low and s_tlast high closes the key without adding a byte
// (an empty key hashes to zero); with both low it is a no-op.
// Output channel m_*: one 32-bit hash per key, issued after its last request.
//
// A byte that completes a 4-byte word adds states K2 and MIX before the next
// request, as the word takes two constant multiplies on the single shared
// multiplier and then the hash mix. Finalisation after the last request runs
// TK1, F1, F2, or TK1, TK2, TX, F0, F1, F2 when tail bytes remain to scramble.
// The result sits in an output register; the next key can be accepted while
// it waits. If the receiver stalls, the block holds the result and stops
// only when a second result is ready to be written.
// Reset clears the key state and the output register; no clearing pass.
`default_nettype none

module murmur3_string_hash (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] key_byte
	input  wire logic [0:0]  s_tuser,   // [0] has_byte
	input  wire logic        s_tlast,   // last
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata    // [31:0] hash_value
);
	import mm3_pkg::*;

	mm3_cmd_t    cmd;
	mm3_status_t status;

	// Sequencer.
	mm3_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.has_byte (s_tuser[0]),
		.last     (s_tlast),
		.status   (status),
		.cmd      (cmd)
	);

	// Hash arithmetic and output register.
	mm3_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.key_byte   (s_tdata),
		.has_byte   (s_tuser[0]),
		.status     (status),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.hash_value (m_tdata)
	);

endmodule

`default_nettype wire
